// ----- src/ccb_pkg.sv -----
package ccb_pkg;

    localparam int MAX_DIMENSION = 1024;
    localparam int CNT_W         = $clog2(MAX_DIMENSION);

    localparam int DIM_W       = 11;
    localparam int COORD_W     = 12;
    localparam int PIXEL_W     = 16;
    localparam int ADDR_W      = 20;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 3;

    // signed destination position: offset plus counter, one bit of headroom
    localparam int POS_W  = ((CNT_W + 1 > COORD_W) ? CNT_W + 1 : COORD_W) + 1;
    localparam int PROD_W = 2 * DIM_W;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_DEST_X       = 3'd0,
        REG_DEST_Y       = 3'd1,
        REG_SRC_WIDTH    = 3'd2,
        REG_SRC_HEIGHT   = 3'd3,
        REG_FB_WIDTH     = 3'd4,
        REG_FB_HEIGHT    = 3'd5,
        REG_KEY_COLOR    = 3'd6,
        REG_SWAP_DISABLE = 3'd7
    } reg_index_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] dest_x;
        logic signed [COORD_W-1:0] dest_y;
        logic [DIM_W-1:0]          src_width;
        logic [DIM_W-1:0]          src_height;
        logic [DIM_W-1:0]          fb_width;
        logic [DIM_W-1:0]          fb_height;
        logic [PIXEL_W-1:0]        key_color;
        logic                      swap_disable;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        dest_x:       '0,
        dest_y:       '0,
        src_width:    DIM_W'(1),
        src_height:   DIM_W'(1),
        fb_width:     DIM_W'(160),
        fb_height:    DIM_W'(128),
        key_color:    '0,
        swap_disable: 1'b0
    };

    typedef struct packed {
        logic [DIM_W-1:0]   col;
        logic [DIM_W-1:0]   row;
        logic [PIXEL_W-1:0] color;
    } blit_op_t;

    typedef struct packed {
        logic     valid;
        blit_op_t op;
    } queue_beat_t;

    function automatic logic [PIXEL_W-1:0] swap_bytes(input logic [PIXEL_W-1:0] v);
        return {v[7:0], v[15:8]};
    endfunction

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        return (32'(v) > MAX_DIMENSION) ? DIM_W'(MAX_DIMENSION) : v;
    endfunction

endpackage

// ----- src/ccb_channels.sv -----
interface ccb_pixel_if;
    import ccb_pkg::*;

    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

interface ccb_write_if;
    import ccb_pkg::*;

    logic               valid;
    logic               ready;
    logic [ADDR_W-1:0]  write_address;
    logic [PIXEL_W-1:0] write_color;

    modport source (output valid, output write_address, output write_color, input ready);
    modport sink   (input valid, input write_address, input write_color, output ready);
endinterface

// ----- src/clipped_color_key_blitter.sv -----
// Colour-keyed clipped blitter: takes 16-bit source pixels in raster order, one per clock
// when neither side stalls, and issues a framebuffer write (address, colour) for each pixel
// that lands inside the framebuffer and is not the key colour. Each write passes through a
// queue entry and then the output register; the write stage forms the address with the single
// row-times-stride multiplier. A four-entry queue between the classifying front end and the
// write stage absorbs short stalls of the write side. Registers are to be written only while
// the block is idle, which the block does not enforce; counters keep their place across writes.
module clipped_color_key_blitter (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              write_enable,
    input  logic [ccb_pkg::CFG_INDEX_W-1:0]   write_index,
    input  logic [ccb_pkg::CFG_DATA_W-1:0]    write_data,
    ccb_pixel_if.sink                         pixel_in,
    ccb_write_if.source                       write_out
);
    import ccb_pkg::*;

    cfg_t        cfg_reg;
    cfg_t        cfg_next;
    queue_beat_t push;
    queue_beat_t head;
    logic        queue_full;
    logic        pop;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (write_enable)
        begin
            unique case (reg_index_t'(write_index))
                REG_DEST_X:       cfg_next.dest_x       = write_data[COORD_W-1:0];
                REG_DEST_Y:       cfg_next.dest_y       = write_data[COORD_W-1:0];
                REG_SRC_WIDTH:    cfg_next.src_width    = write_data[DIM_W-1:0];
                REG_SRC_HEIGHT:   cfg_next.src_height   = write_data[DIM_W-1:0];
                REG_FB_WIDTH:     cfg_next.fb_width     = write_data[DIM_W-1:0];
                REG_FB_HEIGHT:    cfg_next.fb_height    = write_data[DIM_W-1:0];
                REG_KEY_COLOR:    cfg_next.key_color    = write_data[PIXEL_W-1:0];
                REG_SWAP_DISABLE: cfg_next.swap_disable = write_data[0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= CFG_RESET;
        else
            cfg_reg <= cfg_next;
    end

    ccb_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .pixel_in   (pixel_in),
        .queue_full (queue_full),
        .push       (push)
    );

    ccb_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (queue_full),
        .pop   (pop),
        .head  (head)
    );

    ccb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .head      (head),
        .pop       (pop),
        .write_out (write_out)
    );

endmodule

// ----- src/ccb_front.sv -----
module ccb_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ccb_pkg::cfg_t        cfg,
    ccb_pixel_if.sink            pixel_in,
    input  logic                 queue_full,
    output ccb_pkg::queue_beat_t push
);
    import ccb_pkg::*;

    logic [CNT_W-1:0]        col_reg;
    logic [CNT_W-1:0]        col_next;
    logic [CNT_W-1:0]        row_reg;
    logic [CNT_W-1:0]        row_next;
    logic [CNT_W-1:0]        col_eff;
    logic [CNT_W-1:0]        row_eff;
    logic [CNT_W:0]          col_inc;
    logic [CNT_W:0]          row_inc;
    logic [DIM_W-1:0]        w;
    logic [DIM_W-1:0]        h;
    logic signed [POS_W-1:0] dx;
    logic signed [POS_W-1:0] dy;
    logic                    accept;
    logic                    empty_src;
    logic                    in_frame;
    logic                    keyed;

    assign pixel_in.ready = !queue_full;
    assign accept         = pixel_in.valid && pixel_in.ready;

    always_comb
    begin
        w         = clamp_dim(cfg.src_width);
        h         = clamp_dim(cfg.src_height);
        empty_src = (w == '0) || (h == '0);

        // a counter left beyond the source size by a register write restarts at zero
        col_eff = (32'(col_reg) >= 32'(w)) ? '0 : col_reg;
        row_eff = (32'(row_reg) >= 32'(h)) ? '0 : row_reg;
        col_inc = {1'b0, col_eff} + 1'b1;
        row_inc = {1'b0, row_eff} + 1'b1;

        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (empty_src)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (32'(col_inc) >= 32'(w))
            begin
                col_next = '0;
                row_next = (32'(row_inc) >= 32'(h)) ? '0 : row_inc[CNT_W-1:0];
            end
            else
            begin
                col_next = col_inc[CNT_W-1:0];
                row_next = row_eff;
            end
        end
    end

    always_comb
    begin
        dx = $signed(POS_W'(cfg.dest_x)) + $signed(POS_W'(col_eff));
        dy = $signed(POS_W'(cfg.dest_y)) + $signed(POS_W'(row_eff));

        in_frame = !dx[POS_W-1] && !dy[POS_W-1]
                   && (dx < $signed(POS_W'(cfg.fb_width)))
                   && (dy < $signed(POS_W'(cfg.fb_height)));
        keyed    = (pixel_in.pixel == swap_bytes(cfg.key_color));

        push.valid    = accept && !empty_src && in_frame && !keyed;
        push.op.col   = dx[DIM_W-1:0];
        push.op.row   = dy[DIM_W-1:0];
        push.op.color = cfg.swap_disable ? pixel_in.pixel : swap_bytes(pixel_in.pixel);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

// ----- src/ccb_queue.sv -----
module ccb_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ccb_pkg::queue_beat_t push,
    output logic                 full,
    input  logic                 pop,
    output ccb_pkg::queue_beat_t head
);
    import ccb_pkg::*;

    blit_op_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign full       = (32'(count_reg) == QUEUE_DEPTH);
    assign head.valid = (count_reg != '0);
    assign head.op    = entry_reg[rd_ptr_reg];

    assign do_push = push.valid && !full;
    assign do_pop  = pop && head.valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push.op;
    end

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= QUEUE_DEPTH)
        else $error("queue count beyond depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count missed a push");

    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers apart while empty");
`endif

endmodule

// ----- src/ccb_back.sv -----
module ccb_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ccb_pkg::cfg_t        cfg,
    input  ccb_pkg::queue_beat_t head,
    output logic                 pop,
    ccb_write_if.source          write_out
);
    import ccb_pkg::*;

    logic               valid_reg;
    logic               valid_next;
    logic [ADDR_W-1:0]  addr_reg;
    logic [PIXEL_W-1:0] color_reg;
    logic [PROD_W-1:0]  addr_full;

    // the output register takes a new beat when empty or being drained
    assign pop        = head.valid && (!valid_reg || write_out.ready);
    assign valid_next = pop ? 1'b1 : (valid_reg && !write_out.ready);

    assign addr_full = PROD_W'(head.op.row) * PROD_W'(cfg.fb_width) + PROD_W'(head.op.col);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            addr_reg  <= addr_full[ADDR_W-1:0];
            color_reg <= head.op.color;
        end
    end

    assign write_out.valid         = valid_reg;
    assign write_out.write_address = addr_reg;
    assign write_out.write_color   = color_reg;

endmodule

// ----- verif/tb_clipped_color_key_blitter.sv -----
`timescale 1ns / 100ps

module tb_clipped_color_key_blitter;
    import ccb_pkg::*;

    localparam int RANDOM_ITEMS   = 700;
    localparam int PRESSURE_ITEMS = 40;
    localparam int LONG_HOLD      = 300;
    localparam int SETTLE_CYCLES  = 16;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int N_DIRECTED     = 47;

    typedef struct packed {
        logic               is_reg;
        reg_index_t         index;
        logic [15:0]        data;
        logic               literal;
        logic               lit_write;
        logic [ADDR_W-1:0]  lit_address;
        logic [PIXEL_W-1:0] lit_color;
    } stim_row_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  address;
        logic [PIXEL_W-1:0] color;
    } fb_write_t;

    logic                   clk;
    logic                   rst_n;
    logic                   write_enable;
    logic [CFG_INDEX_W-1:0] write_index;
    logic [CFG_DATA_W-1:0]  write_data;

    ccb_pixel_if pixel_if ();
    ccb_write_if write_if ();

    clipped_color_key_blitter uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .write_enable (write_enable),
        .write_index  (write_index),
        .write_data   (write_data),
        .pixel_in     (pixel_if),
        .write_out    (write_if)
    );

    // predictor state
    cfg_t blit_cfg;
    int   src_col;
    int   src_row;

    fb_write_t pending_writes [$];
    int        fail_count      = 0;
    int        cycle_count     = 0;
    int        src_idle_pct    = 0;
    int        sink_stall_pct  = 0;
    int        hold_request_id = 0;

    stim_row_t directed_rows [N_DIRECTED];

    function automatic logic [PIXEL_W-1:0] byte_flip(input logic [PIXEL_W-1:0] v);
        return {v[7:0], v[15:8]};
    endfunction

    function automatic stim_row_t reg_row(input reg_index_t idx, input logic [15:0] data);
        stim_row_t r;
        r = '0;
        r.is_reg = 1'b1;
        r.index  = idx;
        r.data   = data;
        return r;
    endfunction

    function automatic stim_row_t pixel_row(input logic [15:0] pix);
        stim_row_t r;
        r = '0;
        r.index = REG_DEST_X;
        r.data  = pix;
        return r;
    endfunction

    function automatic stim_row_t kept_row(input logic [15:0] pix, input logic [ADDR_W-1:0] addr,
                                           input logic [PIXEL_W-1:0] color);
        stim_row_t r;
        r = pixel_row(pix);
        r.literal     = 1'b1;
        r.lit_write   = 1'b1;
        r.lit_address = addr;
        r.lit_color   = color;
        return r;
    endfunction

    function automatic stim_row_t dropped_row(input logic [15:0] pix);
        stim_row_t r;
        r = pixel_row(pix);
        r.literal = 1'b1;
        return r;
    endfunction

    function automatic void track_reg_write(input reg_index_t idx, input logic [15:0] data);
        case (idx)
            REG_DEST_X:       blit_cfg.dest_x       = data[COORD_W-1:0];
            REG_DEST_Y:       blit_cfg.dest_y       = data[COORD_W-1:0];
            REG_SRC_WIDTH:    blit_cfg.src_width    = data[DIM_W-1:0];
            REG_SRC_HEIGHT:   blit_cfg.src_height   = data[DIM_W-1:0];
            REG_FB_WIDTH:     blit_cfg.fb_width     = data[DIM_W-1:0];
            REG_FB_HEIGHT:    blit_cfg.fb_height    = data[DIM_W-1:0];
            REG_KEY_COLOR:    blit_cfg.key_color    = data[PIXEL_W-1:0];
            REG_SWAP_DISABLE: blit_cfg.swap_disable = data[0];
            default: ;
        endcase
    endfunction

    // work out the write caused by one pixel and advance the raster position
    function automatic bit predict_write(input logic [PIXEL_W-1:0] pix, output fb_write_t w);
        int          wd;
        int          ht;
        int          dx;
        int          dy;
        logic [31:0] lin;
        bit          hit;
        w  = '0;
        wd = (int'(blit_cfg.src_width) > MAX_DIMENSION) ? MAX_DIMENSION
                                                        : int'(blit_cfg.src_width);
        ht = (int'(blit_cfg.src_height) > MAX_DIMENSION) ? MAX_DIMENSION
                                                         : int'(blit_cfg.src_height);
        if (wd == 0 || ht == 0) begin
            src_col = 0;
            src_row = 0;
            return 1'b0;
        end
        if (src_col >= wd)
            src_col = 0;
        if (src_row >= ht)
            src_row = 0;
        dx  = int'($signed(blit_cfg.dest_x)) + src_col;
        dy  = int'($signed(blit_cfg.dest_y)) + src_row;
        hit = dx >= 0 && dy >= 0 && dx < int'(blit_cfg.fb_width) &&
              dy < int'(blit_cfg.fb_height) && pix != byte_flip(blit_cfg.key_color);
        if (hit) begin
            lin       = 32'(dy) * 32'(blit_cfg.fb_width) + 32'(dx);
            w.address = lin[ADDR_W-1:0];
            w.color   = blit_cfg.swap_disable ? pix : byte_flip(pix);
        end
        src_col++;
        if (src_col >= wd) begin
            src_col = 0;
            src_row++;
            if (src_row >= ht)
                src_row = 0;
        end
        return hit;
    endfunction

    function automatic int pick_src_dim(input int small_max);
        int r;
        r = int'($urandom_range(0, 19));
        if (r == 0)
            return 0;
        if (r == 1)
            return int'($urandom_range(MAX_DIMENSION + 1, 2047));
        if (r == 2)
            return MAX_DIMENSION;
        return int'($urandom_range(1, small_max));
    endfunction

    function automatic int pick_fb_dim();
        int r;
        r = int'($urandom_range(0, 19));
        if (r == 0)
            return 0;
        if (r == 1)
            return 2047;
        if (r == 2)
            return int'($urandom_range(1, 2047));
        return int'($urandom_range(1, 48));
    endfunction

    function automatic int pick_offset();
        int r;
        r = int'($urandom_range(0, 19));
        if (r == 0)
            return -2048;
        if (r == 1)
            return 2047;
        if (r == 2)
            return int'($urandom_range(0, 4095)) - 2048;
        return int'($urandom_range(0, 40)) - 8;
    endfunction

    function automatic logic [PIXEL_W-1:0] random_pixel();
        if ($urandom_range(0, 3) == 0)
            return byte_flip(blit_cfg.key_color);
        return 16'($urandom);
    endfunction

    task automatic write_reg(input reg_index_t idx, input logic [15:0] data);
        write_enable <= 1'b1;
        write_index  <= idx;
        write_data   <= data;
        @(negedge clk);
        write_enable <= 1'b0;
        track_reg_write(idx, data);
        @(negedge clk);
    endtask

    // drop valid, wait for every expected write, then let the pipeline empty
    task automatic drain_writes();
        pixel_if.valid <= 1'b0;
        while (pending_writes.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic send_pixel(input logic [PIXEL_W-1:0] pix, input bit literal,
                              input bit lit_write, input fb_write_t lit);
        fb_write_t w;
        bit        hit;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            pixel_if.valid <= 1'b0;
            pixel_if.pixel <= 16'($urandom);
            @(negedge clk);
        end
        pixel_if.valid <= 1'b1;
        pixel_if.pixel <= pix;
        @(posedge clk);
        while (!pixel_if.ready)
            @(posedge clk);
        hit = predict_write(pix, w);
        if (literal) begin
            hit = lit_write;
            w   = lit;
        end
        if (hit)
            pending_writes.push_back(w);
        @(negedge clk);
    endtask

    task automatic reshape_blit();
        logic [15:0] data;
        int          v;
        for (int k = 0; k < 8; k++) begin
            if ($urandom_range(0, 9) < 7) begin
                data = 16'($urandom);
                case (reg_index_t'(k))
                    REG_DEST_X, REG_DEST_Y:
                    begin
                        v = pick_offset();
                        data[COORD_W-1:0] = v[COORD_W-1:0];
                    end
                    REG_SRC_WIDTH:
                    begin
                        v = pick_src_dim(12);
                        data[DIM_W-1:0] = v[DIM_W-1:0];
                    end
                    REG_SRC_HEIGHT:
                    begin
                        v = pick_src_dim(8);
                        data[DIM_W-1:0] = v[DIM_W-1:0];
                    end
                    REG_FB_WIDTH, REG_FB_HEIGHT:
                    begin
                        v = pick_fb_dim();
                        data[DIM_W-1:0] = v[DIM_W-1:0];
                    end
                    default: ;
                endcase
                write_reg(reg_index_t'(k), data);
            end
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // write side: random stalls, plus one long hold-off on request
    initial
    begin
        int hold_left;
        int served_id;
        hold_left      = 0;
        served_id      = 0;
        write_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request_id != served_id) begin
                served_id = hold_request_id;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                write_if.ready <= 1'b0;
            end
            else
                write_if.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        fb_write_t exp_w;
        if (rst_n && write_if.valid && write_if.ready) begin
            if (pending_writes.size() == 0) begin
                $error("unexpected write beat: write_address %0d write_color %h",
                       write_if.write_address, write_if.write_color);
                fail_count++;
            end
            else begin
                exp_w = pending_writes.pop_front();
                if (write_if.write_address !== exp_w.address) begin
                    $error("write_address: expected %0d, actual %0d",
                           exp_w.address, write_if.write_address);
                    fail_count++;
                end
                if (write_if.write_color !== exp_w.color) begin
                    $error("write_color: expected %h, actual %h",
                           exp_w.color, write_if.write_color);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        int n;
        int sent;
        int phase;
        rst_n          = 1'b0;
        write_enable   = 1'b0;
        write_index    = '0;
        write_data     = '0;
        pixel_if.valid = 1'b0;
        pixel_if.pixel = '0;
        blit_cfg       = CFG_RESET;
        src_col        = 0;
        src_row        = 0;

        directed_rows = '{
            kept_row(16'h1234, 20'd0, 16'h3412),
            dropped_row(16'h0000),                  // key colour after reset
            kept_row(16'hFFFF, 20'd0, 16'hFFFF),
            reg_row(REG_SWAP_DISABLE, 16'hFFFF),
            kept_row(16'hA55A, 20'd0, 16'hA55A),
            reg_row(REG_KEY_COLOR, 16'h00F8),
            dropped_row(16'hF800),                  // matches the swapped key
            kept_row(16'h00F8, 20'd0, 16'h00F8),
            reg_row(REG_DEST_X, 16'hFFFF),
            dropped_row(16'h8001),
            reg_row(REG_DEST_X, 16'h0800),
            dropped_row(16'h7FFE),
            reg_row(REG_DEST_X, 16'h07FF),
            dropped_row(16'h1111),
            reg_row(REG_DEST_X, 16'd159),
            reg_row(REG_DEST_Y, 16'd127),
            kept_row(16'h5555, 20'd20479, 16'h5555),
            reg_row(REG_DEST_Y, 16'd128),
            dropped_row(16'hAAAA),
            reg_row(REG_SWAP_DISABLE, 16'h0000),
            reg_row(REG_DEST_X, 16'd0),
            reg_row(REG_DEST_Y, 16'd0),
            reg_row(REG_SRC_WIDTH, 16'd4),
            reg_row(REG_SRC_HEIGHT, 16'd2),
            pixel_row(16'h0102),
            pixel_row(16'hF800),
            pixel_row(16'h0304),
            reg_row(REG_SRC_WIDTH, 16'd2),          // column counter now past the width
            pixel_row(16'h0506),
            pixel_row(16'h0708),
            pixel_row(16'h090A),
            reg_row(REG_SRC_HEIGHT, 16'd0),
            dropped_row(16'h0B0C),
            reg_row(REG_SRC_HEIGHT, 16'd2047),
            reg_row(REG_SRC_WIDTH, 16'd2047),
            pixel_row(16'h0D0E),
            pixel_row(16'h0F10),
            reg_row(REG_FB_WIDTH, 16'd0),
            dropped_row(16'h1213),
            reg_row(REG_FB_WIDTH, 16'd2047),
            reg_row(REG_FB_HEIGHT, 16'd0),
            dropped_row(16'h1415),
            reg_row(REG_FB_HEIGHT, 16'd2047),
            reg_row(REG_SRC_WIDTH, 16'd1),
            reg_row(REG_SRC_HEIGHT, 16'd1),
            reg_row(REG_DEST_Y, 16'd2046),
            kept_row(16'hC3C3, 20'd1042434, 16'hC3C3) // address wraps to 20 bits
        };

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].is_reg) begin
                drain_writes();
                write_reg(directed_rows[i].index, directed_rows[i].data);
            end
            else
                send_pixel(directed_rows[i].data, directed_rows[i].literal,
                           directed_rows[i].lit_write,
                           {directed_rows[i].lit_address, directed_rows[i].lit_color});
        end

        // every pixel lands inside, so a long hold-off fills the block and stalls its input
        drain_writes();
        write_reg(REG_DEST_X, 16'd0);
        write_reg(REG_DEST_Y, 16'd0);
        write_reg(REG_SRC_WIDTH, 16'd8);
        write_reg(REG_SRC_HEIGHT, 16'd8);
        write_reg(REG_FB_WIDTH, 16'd64);
        write_reg(REG_FB_HEIGHT, 16'd64);
        @(posedge clk);
        hold_request_id++;
        @(negedge clk);
        repeat (PRESSURE_ITEMS) send_pixel(16'($urandom), 1'b0, 1'b0, '0);

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            drain_writes();
            case (phase % 4)
                0:
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
                1:
                begin
                    src_idle_pct   = 56;
                    sink_stall_pct = 0;
                end
                2:
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 56;
                end
                default:
                begin
                    src_idle_pct   = 16;
                    sink_stall_pct = 16;
                end
            endcase
            reshape_blit();
            n = int'($urandom_range(8, 48));
            repeat (n) send_pixel(random_pixel(), 1'b0, 1'b0, '0);
            sent += n;
            phase++;
        end

        drain_writes();
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
